>>> hw/rtl/spct_pkg.sv
// Shared types, shape kind codes and default sizes for the shape pair collision test.
// No dependencies; every module of the block imports this package.

package spct_pkg;

    localparam int COORD_W = 18;
    localparam int LIM_W   = 16;
    localparam int SQ_W    = 34;
    localparam int DIST_W  = SQ_W + 1;

    localparam int BLOCK_W_DEF      = 512;
    localparam int BLOCK_H_DEF      = 512;
    localparam int POINT_MARGIN_DEF = 151;

    localparam logic [1:0] KIND_POINT   = 2'd0;
    localparam logic [1:0] KIND_RECT    = 2'd1;
    localparam logic [1:0] KIND_CIRCLE  = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [LIM_W-1:0]          lim_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [DIST_W-1:0]         dist_t;

    typedef enum logic [3:0] {
        MODE_NONE  = 4'b0001,
        MODE_BOX   = 4'b0010,
        MODE_DIST  = 4'b0100,
        MODE_CRECT = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t  mode;
        coord_t ux0;
        coord_t uy0;
        coord_t ux1;
        coord_t uy1;
        coord_t vx0;
        coord_t vy0;
        coord_t vx1;
        coord_t vy1;
        coord_t cx;
        coord_t cy;
        lim_t   lim;
    } prep_t;

    typedef struct packed {
        mode_t  mode;
        logic   box_ok;
        logic   span;
        coord_t dx0;
        coord_t dx1;
        coord_t dy0;
        coord_t dy1;
        lim_t   lim;
    } geom_t;

    typedef struct packed {
        mode_t mode;
        logic  box_ok;
        logic  span;
        sq_t   sx0;
        sq_t   sx1;
        sq_t   sy0;
        sq_t   sy1;
        sq_t   lim2;
    } sqr_t;

endpackage

>>> hw/rtl/spct_prep.sv
// First stage: decode the kinds of both shapes and lay out boxes, centres and limits.
// Depends on spct_pkg.

module spct_prep
    import spct_pkg::*;
#(
    parameter int BLOCK_W      = BLOCK_W_DEF,
    parameter int BLOCK_H      = BLOCK_H_DEF,
    parameter int POINT_MARGIN = POINT_MARGIN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [1:0]  kind_a,
    input  logic [15:0] a_x,
    input  logic [15:0] a_y,
    input  logic [14:0] a_width,
    input  logic [14:0] a_height,
    input  logic [13:0] a_radius,
    input  logic [1:0]  kind_b,
    input  logic [15:0] b_x,
    input  logic [15:0] b_y,
    input  logic [14:0] b_width,
    input  logic [14:0] b_height,
    input  logic [13:0] b_radius,
    output logic        out_valid,
    output prep_t       out_data
);

    localparam coord_t BW   = COORD_W'(BLOCK_W);
    localparam coord_t BH   = COORD_W'(BLOCK_H);
    localparam coord_t BW_H = COORD_W'(BLOCK_W / 2);
    localparam coord_t BH_H = COORD_W'(BLOCK_H / 2);
    localparam lim_t   MARG = LIM_W'(POINT_MARGIN);

    coord_t ax, ay, bx, by;
    coord_t a_ext_x, a_ext_y, b_ext_x, b_ext_y;
    coord_t a_off_x, a_off_y, b_off_x, b_off_y;
    coord_t a_x1, a_y1, b_x1, b_y1;
    coord_t a_cx, a_cy, b_cx, b_cy;
    lim_t   ar, br;
    prep_t  data_next;
    prep_t  data_reg;
    logic   valid_reg;

    always_comb
    begin
        ax = {{(COORD_W-16){a_x[15]}}, a_x};
        ay = {{(COORD_W-16){a_y[15]}}, a_y};
        bx = {{(COORD_W-16){b_x[15]}}, b_x};
        by = {{(COORD_W-16){b_y[15]}}, b_y};
        ar = {{(LIM_W-14){1'b0}}, a_radius};
        br = {{(LIM_W-14){1'b0}}, b_radius};

        // box extent and centre offset per kind
        a_ext_x = {{(COORD_W-15){1'b0}}, a_width};
        a_ext_y = {{(COORD_W-15){1'b0}}, a_height};
        a_off_x = {{(COORD_W-14){1'b0}}, a_radius};
        a_off_y = a_off_x;
        if (kind_a == KIND_POINT)
        begin
            a_ext_x = BW;
            a_ext_y = BH;
            a_off_x = BW_H;
            a_off_y = BH_H;
        end
        else if (kind_a == KIND_CIRCLE)
        begin
            a_ext_x = {{(COORD_W-15){1'b0}}, a_radius, 1'b0};
            a_ext_y = a_ext_x;
        end

        b_ext_x = {{(COORD_W-15){1'b0}}, b_width};
        b_ext_y = {{(COORD_W-15){1'b0}}, b_height};
        b_off_x = {{(COORD_W-14){1'b0}}, b_radius};
        b_off_y = b_off_x;
        if (kind_b == KIND_POINT)
        begin
            b_ext_x = BW;
            b_ext_y = BH;
            b_off_x = BW_H;
            b_off_y = BH_H;
        end
        else if (kind_b == KIND_CIRCLE)
        begin
            b_ext_x = {{(COORD_W-15){1'b0}}, b_radius, 1'b0};
            b_ext_y = b_ext_x;
        end

        a_x1 = ax + a_ext_x;
        a_y1 = ay + a_ext_y;
        b_x1 = bx + b_ext_x;
        b_y1 = by + b_ext_y;
        a_cx = ax + a_off_x;
        a_cy = ay + a_off_y;
        b_cx = bx + b_off_x;
        b_cy = by + b_off_y;

        data_next.mode = MODE_NONE;
        data_next.ux0  = ax;
        data_next.uy0  = ay;
        data_next.ux1  = a_x1;
        data_next.uy1  = a_y1;
        data_next.vx0  = bx;
        data_next.vy0  = by;
        data_next.vx1  = b_x1;
        data_next.vy1  = b_y1;
        data_next.cx   = b_cx;
        data_next.cy   = b_cy;
        data_next.lim  = br;

        if ((kind_a == KIND_POINT || kind_a == KIND_RECT)
            && (kind_b == KIND_POINT || kind_b == KIND_RECT))
        begin
            data_next.mode = MODE_BOX;
        end
        else if (kind_a == KIND_CIRCLE && kind_b == KIND_RECT)
        begin
            // circle a against rectangle b
            data_next.mode = MODE_CRECT;
            data_next.cx   = a_cx;
            data_next.cy   = a_cy;
            data_next.lim  = ar;
        end
        else if (kind_a == KIND_RECT && kind_b == KIND_CIRCLE)
        begin
            // circle b against rectangle a
            data_next.mode = MODE_CRECT;
            data_next.ux0  = bx;
            data_next.uy0  = by;
            data_next.ux1  = b_x1;
            data_next.uy1  = b_y1;
            data_next.vx0  = ax;
            data_next.vy0  = ay;
            data_next.vx1  = a_x1;
            data_next.vy1  = a_y1;
            data_next.cx   = b_cx;
            data_next.cy   = b_cy;
            data_next.lim  = br;
        end
        else if ((kind_a == KIND_CIRCLE || kind_a == KIND_POINT)
                 && (kind_b == KIND_CIRCLE || kind_b == KIND_POINT))
        begin
            // at least one circle here: centre a against centre b
            data_next.mode = MODE_DIST;
            data_next.vx0  = a_cx;
            data_next.vy0  = a_cy;
            data_next.vx1  = a_cx;
            data_next.vy1  = a_cy;
            data_next.cx   = b_cx;
            data_next.cy   = b_cy;
            if (kind_a == KIND_POINT)
                data_next.lim = br + MARG;
            else if (kind_b == KIND_POINT)
                data_next.lim = ar + MARG;
            else
                data_next.lim = ar + br;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/spct_geom.sv
// Second stage: box overlap and centre span compares, corner offsets from the centre.
// Depends on spct_pkg.

module spct_geom
    import spct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  prep_t in_data,
    output logic  out_valid,
    output geom_t out_data
);

    geom_t data_next;
    geom_t data_reg;
    logic  valid_reg;

    always_comb
    begin
        data_next.mode   = in_data.mode;
        data_next.box_ok = !(in_data.ux1 < in_data.vx0) && !(in_data.ux0 > in_data.vx1)
                        && !(in_data.uy1 < in_data.vy0) && !(in_data.uy0 > in_data.vy1);
        data_next.span   = (in_data.cx < in_data.vx1 && in_data.cx > in_data.vx0)
                        || (in_data.cy < in_data.vy1 && in_data.cy > in_data.vy0);
        data_next.dx0    = in_data.vx0 - in_data.cx;
        data_next.dx1    = in_data.vx1 - in_data.cx;
        data_next.dy0    = in_data.vy0 - in_data.cy;
        data_next.dy1    = in_data.vy1 - in_data.cy;
        data_next.lim    = in_data.lim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/spct_square.sv
// Third stage: square the corner offsets and the distance limit.
// Depends on spct_pkg.

module spct_square
    import spct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  geom_t in_data,
    output logic  out_valid,
    output sqr_t  out_data
);

    logic signed [2*COORD_W-1:0] px0, px1, py0, py1;
    logic [2*LIM_W-1:0]          pl;
    sqr_t data_next;
    sqr_t data_reg;
    logic valid_reg;

    always_comb
    begin
        px0 = in_data.dx0 * in_data.dx0;
        px1 = in_data.dx1 * in_data.dx1;
        py0 = in_data.dy0 * in_data.dy0;
        py1 = in_data.dy1 * in_data.dy1;
        pl  = in_data.lim * in_data.lim;

        data_next.mode   = in_data.mode;
        data_next.box_ok = in_data.box_ok;
        data_next.span   = in_data.span;
        data_next.sx0    = px0[SQ_W-1:0];
        data_next.sx1    = px1[SQ_W-1:0];
        data_next.sy0    = py0[SQ_W-1:0];
        data_next.sy1    = py1[SQ_W-1:0];
        data_next.lim2   = {{(SQ_W-2*LIM_W){1'b0}}, pl};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/spct_decide.sv
// Last stage: corner distance sums against the limit and the final verdict per test mode.
// Depends on spct_pkg; its register is the output register of the block.

module spct_decide
    import spct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  sqr_t in_data,
    output logic out_valid,
    output logic out_hit
);

    dist_t d00, d01, d10, d11, lim2;
    logic  near;
    logic  hit_next;
    logic  hit_reg;
    logic  valid_reg;

    always_comb
    begin
        d00  = {1'b0, in_data.sx0} + {1'b0, in_data.sy0};
        d01  = {1'b0, in_data.sx0} + {1'b0, in_data.sy1};
        d10  = {1'b0, in_data.sx1} + {1'b0, in_data.sy0};
        d11  = {1'b0, in_data.sx1} + {1'b0, in_data.sy1};
        lim2 = {1'b0, in_data.lim2};
        near = (d00 <= lim2) || (d01 <= lim2) || (d10 <= lim2) || (d11 <= lim2);

        case (in_data.mode)
            MODE_BOX:   hit_next = in_data.box_ok;
            MODE_DIST:  hit_next = (d00 <= lim2);
            MODE_CRECT: hit_next = in_data.box_ok && (in_data.span || near);
            default:    hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= hit_next;
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;

endmodule

>>> hw/rtl/shape_pair_collision_test_unit.sv
// Top level of the shape pair collision test: stream ports and the four-stage pipeline.
// Depends on spct_pkg, spct_prep, spct_geom, spct_square and spct_decide.

// Takes one shape pair per clock cycle while the pipeline is not held and returns one hit
// flag per pair, in order, through the four register stages (kind decode and layout,
// compares and offsets, squaring, distance verdict), which advance together; the last
// one is the output register. While a result waits and m_axis_tready is low the whole
// pipeline holds, so s_axis_tready follows m_axis_tready or an empty output register
// within the same cycle. The squaring stage holds four corner squarers and one limit squarer.

module shape_pair_collision_test_unit
    import spct_pkg::*;
#(
    parameter int BLOCK_W      = BLOCK_W_DEF,
    parameter int BLOCK_H      = BLOCK_H_DEF,
    parameter int POINT_MARGIN = POINT_MARGIN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_width, a_height, a_radius, b_x, b_y, b_width, b_height, b_radius
    input  logic [151:0] s_axis_tdata,
    // kind_a, kind_b
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, zero padding
    output logic [7:0]   m_axis_tdata
);

    logic  en;
    logic  prep_valid, geom_valid, sqr_valid, out_valid;
    logic  out_hit;
    prep_t prep_data;
    geom_t geom_data;
    sqr_t  sqr_data;

    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    spct_prep #(
        .BLOCK_W      (BLOCK_W),
        .BLOCK_H      (BLOCK_H),
        .POINT_MARGIN (POINT_MARGIN)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .kind_a    (s_axis_tuser[1:0]),
        .a_x       (s_axis_tdata[15:0]),
        .a_y       (s_axis_tdata[31:16]),
        .a_width   (s_axis_tdata[46:32]),
        .a_height  (s_axis_tdata[61:47]),
        .a_radius  (s_axis_tdata[75:62]),
        .kind_b    (s_axis_tuser[3:2]),
        .b_x       (s_axis_tdata[91:76]),
        .b_y       (s_axis_tdata[107:92]),
        .b_width   (s_axis_tdata[122:108]),
        .b_height  (s_axis_tdata[137:123]),
        .b_radius  (s_axis_tdata[151:138]),
        .out_valid (prep_valid),
        .out_data  (prep_data)
    );

    spct_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (geom_valid),
        .out_data  (geom_data)
    );

    spct_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geom_valid),
        .in_data   (geom_data),
        .out_valid (sqr_valid),
        .out_data  (sqr_data)
    );

    spct_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqr_valid),
        .in_data   (sqr_data),
        .out_valid (out_valid),
        .out_hit   (out_hit)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {7'b0, out_hit};

endmodule

>>> hw/rtl/spct_checker.sv
// Port-level checks for the shape pair collision test, bound to the top level.
// Depends on spct_pkg for the kind codes and on shape_pair_collision_test_unit as bind target.

module spct_checker
    import spct_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [3:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [7:0]   m_axis_tdata
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

    // an empty output register never blocks a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

    // a stalled result blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while output stalled");

    // an invalid kind_a, flowing through all stages without stall, gives a miss
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == KIND_INVALID)
        ##1 s_axis_tready ##1 s_axis_tready ##1 s_axis_tready
        |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("invalid kind reported a hit");

    // padding bits stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("result padding not zero");

endmodule

bind shape_pair_collision_test_unit spct_checker u_spct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/shape_pair_collision_test_checker.sv
// Checker for the shape pair collision test: watches both stream channels, works out
// the expected hit flag of every accepted request and compares it with each result.
// Depends on spct_pkg for the shape kind codes and the default block sizes.
`timescale 1ns / 1ps

module shape_pair_collision_test_checker
    import spct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // a_x, a_y, a_width, a_height, a_radius, b_x, b_y, b_width, b_height, b_radius
    input  logic [151:0] s_tdata,
    // kind_a, kind_b
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // hit, zero padding
    input  logic [7:0]   m_tdata,
    output int           pending,
    output int           fails
);

    localparam longint BLK_W  = BLOCK_W_DEF;
    localparam longint BLK_H  = BLOCK_H_DEF;
    localparam longint MARGIN = POINT_MARGIN_DEF;

    typedef struct {
        logic [1:0] kind;
        longint     x;
        longint     y;
        longint     w;
        longint     h;
        longint     r;
    } shape_t;

    logic expected_hits[$];
    logic want_hit;
    int   result_no;

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", result_no, what);
        fails = fails + 1;
    endtask

    function automatic shape_t unpack_shape(input logic [1:0] kind, input logic [75:0] f);
        shape_t s;
        s.kind = kind;
        s.x    = $signed(f[15:0]);
        s.y    = $signed(f[31:16]);
        s.w    = f[46:32];
        s.h    = f[61:47];
        s.r    = f[75:62];
        return s;
    endfunction

    function automatic logic boxes_touch(input longint ax, input longint ay,
                                         input longint aw, input longint ah,
                                         input longint bx, input longint by,
                                         input longint bw, input longint bh);
        return !(ax + aw < bx || ax > bx + bw || ay + ah < by || ay > by + bh);
    endfunction

    function automatic longint sq_distance(input longint x0, input longint y0,
                                           input longint x1, input longint y1);
        longint dx;
        longint dy;
        dx = x0 - x1;
        dy = y0 - y1;
        return dx * dx + dy * dy;
    endfunction

    function automatic logic point_in_circle(input shape_t p, input shape_t c);
        longint lim;
        lim = c.r + MARGIN;
        return sq_distance(p.x + BLK_W / 2, p.y + BLK_H / 2, c.x + c.r, c.y + c.r)
               <= lim * lim;
    endfunction

    function automatic logic circles_meet(input shape_t a, input shape_t b);
        longint lim;
        lim = a.r + b.r;
        return sq_distance(a.x + a.r, a.y + a.r, b.x + b.r, b.y + b.r) <= lim * lim;
    endfunction

    function automatic logic circle_meets_rect(input shape_t c, input shape_t q);
        longint cx;
        longint cy;
        longint r2;
        cx = c.x + c.r;
        cy = c.y + c.r;
        r2 = c.r * c.r;
        if (q.y + q.h < c.y || q.y > c.y + 2 * c.r) return 1'b0;
        if (q.x + q.w < c.x || q.x > c.x + 2 * c.r) return 1'b0;
        if (cx < q.x + q.w && cx > q.x) return 1'b1;
        if (cy < q.y + q.h && cy > q.y) return 1'b1;
        return sq_distance(q.x, q.y, cx, cy) <= r2
            || sq_distance(q.x, q.y + q.h, cx, cy) <= r2
            || sq_distance(q.x + q.w, q.y, cx, cy) <= r2
            || sq_distance(q.x + q.w, q.y + q.h, cx, cy) <= r2;
    endfunction

    function automatic logic collide_pair(input shape_t a, input shape_t b);
        if (a.kind == KIND_POINT) begin
            if (b.kind == KIND_POINT)
                return boxes_touch(a.x, a.y, BLK_W, BLK_H, b.x, b.y, BLK_W, BLK_H);
            if (b.kind == KIND_CIRCLE) return point_in_circle(a, b);
            if (b.kind == KIND_RECT)
                return boxes_touch(a.x, a.y, BLK_W, BLK_H, b.x, b.y, b.w, b.h);
            return 1'b0;
        end
        if (a.kind == KIND_RECT) begin
            if (b.kind == KIND_POINT)
                return boxes_touch(b.x, b.y, BLK_W, BLK_H, a.x, a.y, a.w, a.h);
            if (b.kind == KIND_CIRCLE) return circle_meets_rect(b, a);
            if (b.kind == KIND_RECT)
                return boxes_touch(a.x, a.y, a.w, a.h, b.x, b.y, b.w, b.h);
            return 1'b0;
        end
        if (a.kind == KIND_CIRCLE) begin
            if (b.kind == KIND_POINT) return point_in_circle(b, a);
            if (b.kind == KIND_CIRCLE) return circles_meet(a, b);
            if (b.kind == KIND_RECT) return circle_meets_rect(a, b);
            return 1'b0;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_hits = {expected_hits,
                                 collide_pair(unpack_shape(s_tuser[1:0], s_tdata[75:0]),
                                              unpack_shape(s_tuser[3:2], s_tdata[151:76]))};
            if (m_tvalid && m_tready)
            begin
                if (expected_hits.size() == 0)
                begin
                    report_mismatch("result with no request pending");
                end
                else
                begin
                    want_hit = expected_hits.pop_front();
                    if (m_tdata[0] !== want_hit)
                        report_mismatch($sformatf("hit %b, expected %b", m_tdata[0], want_hit));
                end
                result_no = result_no + 1;
            end
            pending <= expected_hits.size();
        end
    end

endmodule

>>> verif/shape_pair_collision_test_unit_test.sv
// Testbench top for the shape pair collision test: clock, reset, stimulus and verdict.
// Depends on spct_pkg, shape_pair_collision_test_unit and shape_pair_collision_test_checker.
`timescale 1ns / 1ps

module shape_pair_collision_test_unit_test;
    import spct_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // a_x, a_y, a_width, a_height, a_radius, b_x, b_y, b_width, b_height, b_radius
    logic [151:0] s_axis_tdata;
    // kind_a, kind_b
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // hit, zero padding
    logic [7:0]   m_axis_tdata;

    int pending;
    int fails;
    int idle_cycles;
    bit sender_idles;
    bit sink_idles;
    bit hold_request;

    shape_pair_collision_test_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    shape_pair_collision_test_checker collision_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .pending  (pending),
        .fails    (fails)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pair(input int ka, input int ax, input int ay, input int aw,
                             input int ah, input int ar, input int kb, input int bx,
                             input int by, input int bw, input int bh, input int br);
        int gap;
        gap = sender_idles ? gap_length() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {br[13:0], bh[14:0], bw[14:0], by[15:0], bx[15:0],
                         ar[13:0], ah[14:0], aw[14:0], ay[15:0], ax[15:0]};
        s_axis_tuser  = {kb[1:0], ka[1:0]};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic random_pair();
        int ka;
        int kb;
        int ax;
        int ay;
        int bx;
        int by;
        int sz[4];
        int rad[2];
        ka = ($urandom_range(0, 15) == 15) ? KIND_INVALID : $urandom_range(0, 2);
        kb = ($urandom_range(0, 15) == 15) ? KIND_INVALID : $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 20)
        begin
            send_pair(ka, $urandom, $urandom, $urandom, $urandom, $urandom,
                      kb, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            ax = $urandom_range(0, 60000) - 30000;
            ay = $urandom_range(0, 60000) - 30000;
            bx = ax + $urandom_range(0, 4000) - 2000;
            by = ay + $urandom_range(0, 4000) - 2000;
            foreach (sz[i])
                sz[i] = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 1200)
                                                    : $urandom_range(0, 32767);
            foreach (rad[i])
                rad[i] = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 800)
                                                     : $urandom_range(0, 16383);
            send_pair(ka, ax, ay, sz[0], sz[1], rad[0], kb, bx, by, sz[2], sz[3], rad[1]);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            int n;
            @(negedge clk);
            if (hold_request)
            begin
                hold_request  = 1'b0;
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            n = sink_idles ? gap_length() : 0;
            if (n > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        sender_idles  = 1'b1;
        sink_idles    = 1'b1;
        hold_request  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every kind pairing on overlapping shapes
        for (int ka = 0; ka < 4; ka++)
            for (int kb = 0; kb < 4; kb++)
                send_pair(ka, 0, 0, 600, 600, 300, kb, 100, 100, 600, 600, 300);

        // touching blocks, with unused fields at their maximum, then blocks one step apart
        send_pair(KIND_POINT, 0, 0, 32767, 32767, 16383,
                  KIND_POINT, 512, 512, 32767, 32767, 16383);
        send_pair(KIND_POINT, 0, 0, 0, 0, 0, KIND_POINT, 513, 0, 0, 0, 0);
        // distance exactly at the limit, then one step beyond
        send_pair(KIND_CIRCLE, 0, 0, 0, 0, 100, KIND_CIRCLE, 200, 50, 0, 0, 50);
        send_pair(KIND_POINT, 0, 0, 0, 0, 0, KIND_CIRCLE, 407, 256, 0, 0, 0);
        send_pair(KIND_POINT, 0, 0, 0, 0, 0, KIND_CIRCLE, 408, 256, 0, 0, 0);
        // centre inside span, corner inside, corner just outside
        send_pair(KIND_CIRCLE, 0, 0, 0, 0, 100, KIND_RECT, 50, 190, 100, 10, 0);
        send_pair(KIND_RECT, 170, 170, 10, 10, 0, KIND_CIRCLE, 0, 0, 0, 0, 100);
        send_pair(KIND_CIRCLE, 0, 0, 0, 0, 100, KIND_RECT, 171, 171, 10, 10, 0);
        // coordinate and size extremes
        send_pair(KIND_RECT, -32768, -32768, 32767, 32767, 0,
                  KIND_RECT, 32767, 32767, 32767, 32767, 0);
        send_pair(KIND_CIRCLE, -32768, -32768, 0, 0, 16383,
                  KIND_CIRCLE, 32767, 32767, 0, 0, 16383);

        repeat (200) random_pair();

        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        repeat (60) random_pair();

        // hold the sink off while requests keep coming
        hold_request = 1'b1;
        repeat (40) random_pair();
        drain();

        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        repeat (80) random_pair();
        drain();
        repeat (10) @(posedge clk);

        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> shape_pair_collision_test_unit.f
hw/rtl/spct_pkg.sv
hw/rtl/spct_prep.sv
hw/rtl/spct_geom.sv
hw/rtl/spct_square.sv
hw/rtl/spct_decide.sv
hw/rtl/shape_pair_collision_test_unit.sv
hw/rtl/spct_checker.sv
verif/shape_pair_collision_test_checker.sv
verif/shape_pair_collision_test_unit_test.sv
